// ----- src/bfca_pkg.sv -----
// Shared types, codes and the MurmurHash2 mixing function of the Bloom filter.
// No dependencies.
`timescale 1ns / 1ps

package bfca_pkg;

    localparam logic [31:0] MIX_M      = 32'h5bd1e995;
    localparam logic [31:0] FIRST_SEED = 32'h9747b28c;
    localparam int          KEY_W      = 64;
    localparam int          KLEN_W     = 4;

    localparam logic [1:0] CMD_CHECK = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] STATUS_ABSENT   = 2'd0;
    localparam logic [1:0] STATUS_PRESENT  = 2'd1;
    localparam logic [1:0] STATUS_DISABLED = 2'd2;

    localparam logic [7:0] REG_FILTER_ENABLED = 8'd0;
    localparam logic [7:0] REG_NUM_BITS       = 8'd1;
    localparam logic [7:0] REG_NUM_HASHES     = 8'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH_A,
        S_HASH_B,
        S_MOD_A,
        S_MOD_B,
        S_PRB_RD,
        S_PRB_CHK,
        S_DONE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        H_IDLE,
        H_K1,
        H_K2,
        H_H,
        H_TAIL,
        H_FIN,
        H_DONE
    } hash_state_t;

    typedef struct packed {
        logic              start;
        logic [31:0]       seed;
        logic [KLEN_W-1:0] key_len;
    } hash_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } hash_rsp_t;

    function automatic logic [31:0] mulm(input logic [31:0] x);
        logic [63:0] p;
        p = {32'd0, x} * {32'd0, MIX_M};
        return p[31:0];
    endfunction

endpackage

// ----- src/bfca_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module bfca_ram #(
    parameter int              WIDTH = 8,
    parameter longint unsigned DEPTH = 131072
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/bfca_hash.sv -----
// 32-bit MurmurHash2 of a key of up to eight bytes, one multiply per cycle.
// Depends on bfca_pkg.
`timescale 1ns / 1ps

module bfca_hash (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bfca_pkg::hash_req_t         req,
    input  logic [bfca_pkg::KEY_W-1:0]  key,
    output bfca_pkg::hash_rsp_t         rsp
);

    bfca_pkg::hash_state_t state_reg, state_next;
    logic [31:0]                  h_reg, h_next;
    logic [31:0]                  k_reg, k_next;
    logic [bfca_pkg::KLEN_W-1:0]  rest_reg, rest_next;
    logic                         blk_reg, blk_next;
    logic [bfca_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [31:0]                  word;
    logic [31:0]                  tail_mask;
    logic [31:0]                  mul_in;
    logic [31:0]                  prod;
    logic [bfca_pkg::KLEN_W-1:0]  rest_after;

    assign word       = blk_reg ? key_reg[63:32] : key_reg[31:0];
    assign rest_after = rest_reg - bfca_pkg::KLEN_W'(4);

    always_comb
    begin
        case (rest_reg[1:0])
            2'd1:    tail_mask = 32'h0000_00ff;
            2'd2:    tail_mask = 32'h0000_ffff;
            2'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'h0000_0000;
        endcase
    end

    // One shared multiplier, operand picked by step
    always_comb
    begin
        case (state_reg)
            bfca_pkg::H_K1, bfca_pkg::H_K2: mul_in = k_reg;
            bfca_pkg::H_TAIL:               mul_in = h_reg ^ (word & tail_mask);
            bfca_pkg::H_FIN:                mul_in = h_reg ^ (h_reg >> 13);
            default:                        mul_in = h_reg;
        endcase
    end

    assign prod = bfca_pkg::mulm(mul_in);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfca_pkg::H_IDLE:
            begin
                if (req.start)
                begin
                    if (req.key_len >= bfca_pkg::KLEN_W'(4))
                        state_next = bfca_pkg::H_K1;
                    else if (req.key_len != '0)
                        state_next = bfca_pkg::H_TAIL;
                    else
                        state_next = bfca_pkg::H_FIN;
                end
            end
            bfca_pkg::H_K1: state_next = bfca_pkg::H_K2;
            bfca_pkg::H_K2: state_next = bfca_pkg::H_H;
            bfca_pkg::H_H:
            begin
                if (rest_after >= bfca_pkg::KLEN_W'(4))
                    state_next = bfca_pkg::H_K1;
                else if (rest_after != '0)
                    state_next = bfca_pkg::H_TAIL;
                else
                    state_next = bfca_pkg::H_FIN;
            end
            bfca_pkg::H_TAIL: state_next = bfca_pkg::H_FIN;
            bfca_pkg::H_FIN:  state_next = bfca_pkg::H_DONE;
            bfca_pkg::H_DONE:
            begin
                if (req.start)
                begin
                    if (req.key_len >= bfca_pkg::KLEN_W'(4))
                        state_next = bfca_pkg::H_K1;
                    else if (req.key_len != '0)
                        state_next = bfca_pkg::H_TAIL;
                    else
                        state_next = bfca_pkg::H_FIN;
                end
                else
                    state_next = bfca_pkg::H_IDLE;
            end
            default: state_next = bfca_pkg::H_IDLE;
        endcase
    end

    always_comb
    begin
        h_next    = h_reg;
        k_next    = k_reg;
        rest_next = rest_reg;
        blk_next  = blk_reg;
        key_next  = key_reg;
        if ((state_reg == bfca_pkg::H_IDLE || state_reg == bfca_pkg::H_DONE) && req.start)
        begin
            h_next    = req.seed ^ {28'd0, req.key_len};
            k_next    = key[31:0];
            rest_next = req.key_len;
            blk_next  = 1'b0;
            key_next  = key;
        end
        else
        begin
            case (state_reg)
                bfca_pkg::H_K1: k_next = prod ^ (prod >> 24);
                bfca_pkg::H_K2: k_next = prod;
                bfca_pkg::H_H:
                begin
                    h_next    = prod ^ k_reg;
                    k_next    = key_reg[63:32];
                    rest_next = rest_after;
                    blk_next  = 1'b1;
                end
                bfca_pkg::H_TAIL: h_next = prod;
                bfca_pkg::H_FIN:  h_next = prod;
                default:          h_next = h_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfca_pkg::H_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        k_reg    <= k_next;
        rest_reg <= rest_next;
        blk_reg  <= blk_next;
        key_reg  <= key_next;
    end

    assign rsp.done  = (state_reg == bfca_pkg::H_DONE);
    assign rsp.value = h_reg ^ (h_reg >> 15);

endmodule

// ----- src/bfca_modred.sv -----
// Bit-serial reduction of a 32-bit value modulo the probe modulus.
// Depends on bfca_pkg.
`timescale 1ns / 1ps

module bfca_modred #(
    parameter int MOD_W = 21
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      value,
    input  logic [MOD_W-1:0] modulus,
    output bfca_pkg::hash_rsp_t rsp,
    output logic [MOD_W-1:0] result
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [31:0]      val_reg, val_next;
    logic [MOD_W-1:0] r_reg, r_next;
    logic [MOD_W:0]   trial;
    logic [MOD_W:0]   reduced;

    assign trial   = {r_reg, val_reg[31]};
    assign reduced = (trial >= {1'b0, modulus}) ? trial - {1'b0, modulus} : trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            val_next  = value;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next   = reduced[MOD_W-1:0];
            val_next = {val_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        val_reg <= val_next;
        r_reg   <= r_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = 32'(r_reg);
    assign result    = r_reg;

endmodule

// ----- src/bloom_filter_check_add_unit.sv -----
// Top level of the Bloom filter check/add unit: control sequencer and bit store.
// Depends on bfca_pkg, bfca_ram, bfca_hash and bfca_modred.
`timescale 1ns / 1ps

// Usage
// - Slave stream carries one request per transaction: tuser is the command
//   (check, add, clear), tdata the key and its byte count. Master stream
//   returns one status per request.
// - Config channel (cfg_valid/cfg_ready, always ready) writes filter_enabled,
//   num_bits and num_hashes by index; write only while the unit is idle.
// - Requests are handled one at a time; s_tready is high only when the
//   sequencer is idle. A check or add runs two hash passes through the
//   shared multiplier, the serial reduction of a and b mod num_bits, then
//   per probe a store read followed by the check and optional write back,
//   and hands off to the output register. A disabled filter or an unknown
//   command answers without hashing.
// - Clear sweeps the whole store one byte per cycle.
// - After reset the same sweep runs over the store (131072 bytes at the default)
//   and no request is taken until it ends; config writes are taken throughout.
// - A stalled receiver holds the status in the output register; the next
//   request may be accepted and processed meanwhile and waits at its end.

module bloom_filter_check_add_unit #(
    parameter longint unsigned MAX_BITS  = 1048576,
    parameter int              KEY_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // key [63:0], key_length [67:64], zero pad
    input  logic [1:0]  s_tuser,   // command [1:0]
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // status [1:0], zero pad
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam longint unsigned STORE_BYTES = (MAX_BITS + 7) / 8;
    localparam int              AW          = $clog2(STORE_BYTES);
    localparam int              MOD_W       = $clog2(MAX_BITS + 1);

    // config registers
    logic        filter_enabled_reg;
    logic [20:0] num_bits_reg;
    logic [6:0]  num_hashes_reg;

    bfca_pkg::ctrl_state_t state_reg, state_next;

    logic                         clr_reply_reg, clr_reply_next;
    logic [AW-1:0]                clr_cnt_reg, clr_cnt_next;
    logic [bfca_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [bfca_pkg::KLEN_W-1:0]  klen_reg, klen_next;
    logic                         add_reg, add_next;
    logic [31:0]                  a_reg, a_next;
    logic [31:0]                  b_reg, b_next;
    logic [MOD_W-1:0]             x_reg, x_next;
    logic [MOD_W-1:0]             step_reg, step_next;
    logic [6:0]                   i_reg, i_next;
    logic                         all_hit_reg, all_hit_next;
    logic [1:0]                   res_reg, res_next;
    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   status_reg, status_next;

    logic                         accept;
    logic [1:0]                   in_cmd;
    logic [bfca_pkg::KLEN_W-1:0]  in_klen;
    logic [bfca_pkg::KLEN_W-1:0]  sat_klen;
    logic [63:0]                  nb_wide;
    logic [MOD_W-1:0]             modulus;
    logic [MOD_W:0]               x_sum;
    logic [MOD_W-1:0]             x_adv;
    logic                         probe_bit;
    logic                         out_load;

    bfca_pkg::hash_req_t          hash_req;
    bfca_pkg::hash_rsp_t          hash_rsp;
    logic [bfca_pkg::KEY_W-1:0]   hash_key;
    logic                         mod_start;
    logic [31:0]                  mod_value;
    bfca_pkg::hash_rsp_t          mod_rsp;
    logic [MOD_W-1:0]             mod_result;

    logic                         ram_we;
    logic [AW-1:0]                ram_addr;
    logic [7:0]                   ram_wdata;
    logic [7:0]                   ram_rdata;

    assign in_cmd   = s_tuser;
    assign in_klen  = s_tdata[67:64];
    assign sat_klen = (in_klen > bfca_pkg::KLEN_W'(KEY_BYTES)) ?
                      bfca_pkg::KLEN_W'(KEY_BYTES) : in_klen;
    assign s_tready = (state_reg == bfca_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // zero means one bit, anything above the store saturates
    assign nb_wide = 64'(num_bits_reg);
    assign modulus = (nb_wide == 64'd0) ? MOD_W'(1) :
                     (nb_wide > 64'(MAX_BITS)) ? MOD_W'(MAX_BITS) : MOD_W'(nb_wide);

    // next probe position: both terms are below the modulus
    assign x_sum = {1'b0, x_reg} + {1'b0, step_reg};
    assign x_adv = (x_sum >= {1'b0, modulus}) ? MOD_W'(x_sum - {1'b0, modulus}) :
                   MOD_W'(x_sum);

    assign probe_bit = ram_rdata[x_reg[2:0]];
    assign out_load  = (state_reg == bfca_pkg::S_DONE) && (!out_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfca_pkg::S_CLEAR:
            begin
                if (clr_cnt_reg == AW'(STORE_BYTES - 1))
                    state_next = clr_reply_reg ? bfca_pkg::S_DONE : bfca_pkg::S_IDLE;
            end
            bfca_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (!filter_enabled_reg)
                        state_next = bfca_pkg::S_DONE;
                    else if (in_cmd == bfca_pkg::CMD_CLEAR)
                        state_next = bfca_pkg::S_CLEAR;
                    else if (in_cmd == bfca_pkg::CMD_CHECK || in_cmd == bfca_pkg::CMD_ADD)
                        state_next = bfca_pkg::S_HASH_A;
                    else
                        state_next = bfca_pkg::S_DONE;
                end
            end
            bfca_pkg::S_HASH_A: if (hash_rsp.done) state_next = bfca_pkg::S_HASH_B;
            bfca_pkg::S_HASH_B: if (hash_rsp.done) state_next = bfca_pkg::S_MOD_A;
            bfca_pkg::S_MOD_A:  if (mod_rsp.done)  state_next = bfca_pkg::S_MOD_B;
            bfca_pkg::S_MOD_B:
            begin
                if (mod_rsp.done)
                    state_next = (num_hashes_reg == 7'd0) ? bfca_pkg::S_DONE :
                                                            bfca_pkg::S_PRB_RD;
            end
            bfca_pkg::S_PRB_RD: state_next = bfca_pkg::S_PRB_CHK;
            bfca_pkg::S_PRB_CHK:
            begin
                if ((!probe_bit && !add_reg) || (i_reg + 7'd1 == num_hashes_reg))
                    state_next = bfca_pkg::S_DONE;
                else
                    state_next = bfca_pkg::S_PRB_RD;
            end
            bfca_pkg::S_DONE: if (out_load) state_next = bfca_pkg::S_IDLE;
            default: state_next = bfca_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        clr_reply_next = clr_reply_reg;
        clr_cnt_next   = clr_cnt_reg;
        key_next       = key_reg;
        klen_next      = klen_reg;
        add_next       = add_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        x_next         = x_reg;
        step_next      = step_reg;
        i_next         = i_reg;
        all_hit_next   = all_hit_reg;
        res_next       = res_reg;
        hash_req.start   = 1'b0;
        hash_req.seed    = bfca_pkg::FIRST_SEED;
        hash_req.key_len = sat_klen;
        hash_key         = s_tdata[63:0];
        mod_start      = 1'b0;
        mod_value      = a_reg;
        ram_we         = 1'b0;
        ram_addr       = AW'(x_reg >> 3);
        ram_wdata      = ram_rdata | (8'd1 << x_reg[2:0]);

        unique case (state_reg)
            bfca_pkg::S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = 8'd0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                res_next     = bfca_pkg::STATUS_ABSENT;
            end
            bfca_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    key_next       = s_tdata[63:0];
                    klen_next      = sat_klen;
                    add_next       = (in_cmd == bfca_pkg::CMD_ADD);
                    clr_cnt_next   = '0;
                    clr_reply_next = 1'b1;
                    res_next       = bfca_pkg::STATUS_ABSENT;
                    if (!filter_enabled_reg)
                        res_next = bfca_pkg::STATUS_DISABLED;
                    else if (in_cmd == bfca_pkg::CMD_CHECK || in_cmd == bfca_pkg::CMD_ADD)
                        hash_req.start = 1'b1;
                end
            end
            bfca_pkg::S_HASH_A:
            begin
                hash_req.seed    = hash_rsp.value;
                hash_req.key_len = klen_reg;
                hash_key         = key_reg;
                if (hash_rsp.done)
                begin
                    a_next         = hash_rsp.value;
                    hash_req.start = 1'b1;
                end
            end
            bfca_pkg::S_HASH_B:
            begin
                hash_req.key_len = klen_reg;
                hash_key         = key_reg;
                if (hash_rsp.done)
                begin
                    b_next    = hash_rsp.value;
                    mod_start = 1'b1;
                    mod_value = a_reg;
                end
            end
            bfca_pkg::S_MOD_A:
            begin
                if (mod_rsp.done)
                begin
                    x_next    = mod_result;
                    mod_start = 1'b1;
                    mod_value = b_reg;
                end
            end
            bfca_pkg::S_MOD_B:
            begin
                if (mod_rsp.done)
                begin
                    step_next    = mod_result;
                    i_next       = 7'd0;
                    all_hit_next = 1'b1;
                    res_next     = bfca_pkg::STATUS_PRESENT;
                end
            end
            bfca_pkg::S_PRB_CHK:
            begin
                // miss on check ends the run; miss on add sets the bit
                i_next = i_reg + 7'd1;
                x_next = x_adv;
                if (!probe_bit)
                begin
                    all_hit_next = 1'b0;
                    ram_we       = add_reg;
                end
                res_next = (all_hit_reg && probe_bit) ? bfca_pkg::STATUS_PRESENT :
                                                        bfca_pkg::STATUS_ABSENT;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            status_next    = res_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, status_reg};

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enabled_reg <= 1'b0;
            num_bits_reg       <= 21'd1048576;
            num_hashes_reg     <= 7'd7;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bfca_pkg::REG_FILTER_ENABLED: filter_enabled_reg <= cfg_data[0];
                bfca_pkg::REG_NUM_BITS:       num_bits_reg       <= cfg_data[20:0];
                bfca_pkg::REG_NUM_HASHES:     num_hashes_reg     <= cfg_data[6:0];
                default:                      filter_enabled_reg <= filter_enabled_reg;
            endcase
        end
    end

    // control state; reset starts the clearing sweep with no reply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfca_pkg::S_CLEAR;
            clr_reply_reg <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reply_reg <= clr_reply_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        klen_reg    <= klen_next;
        add_reg     <= add_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        x_reg       <= x_next;
        step_reg    <= step_next;
        i_reg       <= i_next;
        all_hit_reg <= all_hit_next;
        res_reg     <= res_next;
        status_reg  <= status_next;
    end

    bfca_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hash_req),
        .key   (hash_key),
        .rsp   (hash_rsp)
    );

    bfca_modred #(
        .MOD_W (MOD_W)
    ) u_modred (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .value   (mod_value),
        .modulus (modulus),
        .rsp     (mod_rsp),
        .result  (mod_result)
    );

    bfca_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

`ifndef NO_ASSERTIONS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfca_pkg::S_CLEAR) |-> !s_tready)
        else $error("request accepted during store sweep");

    a_write_only_sweep_or_add: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == bfca_pkg::S_CLEAR ||
                    (state_reg == bfca_pkg::S_PRB_CHK && add_reg)))
        else $error("store written outside sweep or add");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfca_pkg::S_PRB_RD) |-> (x_reg < modulus && i_reg < num_hashes_reg))
        else $error("probe position or count out of range");

    a_chk_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfca_pkg::S_PRB_CHK) |-> ($past(state_reg) == bfca_pkg::S_PRB_RD))
        else $error("probe check without store read");
`endif

endmodule
